// ----- src/acr_pkg.sv -----
// ----------------------------------------------------------------------------
// acr_pkg: shared types and constants for the box collision resolver
// widths of the box fields, the packed stream layouts and the relation codes
// ----------------------------------------------------------------------------
package acr_pkg;

	// field widths
	localparam int COORD_BITS = 16;
	localparam int HALF_BITS  = COORD_BITS - 2;
	localparam int PUSH_BITS  = COORD_BITS + 2;
	localparam int EDGE_BITS  = COORD_BITS + 1;
	localparam int ABS_BITS   = COORD_BITS;
	localparam int HPROD_BITS = 2 * HALF_BITS;
	localparam int XPROD_BITS = ABS_BITS + HPROD_BITS;

	// input stream layout, first field in the lowest bits
	localparam int IN_RAW_BITS  = 4 * COORD_BITS + 4 * HALF_BITS;
	localparam int IN_DATA_BITS = ((IN_RAW_BITS + 7) / 8) * 8;
	localparam int OCX_LSB = 0;
	localparam int OCY_LSB = OCX_LSB + COORD_BITS;
	localparam int OHW_LSB = OCY_LSB + COORD_BITS;
	localparam int OHH_LSB = OHW_LSB + HALF_BITS;
	localparam int RCX_LSB = OHH_LSB + HALF_BITS;
	localparam int RCY_LSB = RCX_LSB + COORD_BITS;
	localparam int RHW_LSB = RCY_LSB + COORD_BITS;
	localparam int RHH_LSB = RHW_LSB + HALF_BITS;

	// output stream layout
	localparam int OUT_RAW_BITS  = 1 + 2 + 2 * PUSH_BITS;
	localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

	// side of the reference on which the object lies
	typedef enum logic [1:0] {
		REL_NORTH = 2'd0,
		REL_SOUTH = 2'd1,
		REL_WEST  = 2'd2,
		REL_EAST  = 2'd3
	} rel_t;

	// per-stage load enables from the handshake control to the datapath
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} adv_t;

endpackage

// ----- src/aabb_collision_resolve.sv -----
// ----------------------------------------------------------------------------
// aabb_collision_resolve: box overlap test and push-out correction
// one object box and one reference box in, overlap flag, relation and an
// axis-chosen correction out, on streaming channels
// ----------------------------------------------------------------------------
//
// channel | direction | handshake          | tdata fields, lowest bit first
// --------+-----------+--------------------+----------------------------------
// s_      | in        | s_tvalid/s_tready  | obj_center_x, obj_center_y,
//         |           |                    | obj_half_w, obj_half_h,
//         |           |                    | ref_center_x, ref_center_y,
//         |           |                    | ref_half_w, ref_half_h
// m_      | out       | m_tvalid/m_tready  | overlap, relation, push_x, push_y
//
// m_tvalid rises once an accepted transaction has passed the three register
// stages (edges and half-size products, cross products, axis choice); one
// transaction per cycle while the output is not stalled.
// the last stage is the output register; each stage loads whenever it is
// empty or the stage after it moves, so a stall backs up stage by stage.
// reset clears only the stage valid bits; there is no state between items.
//
module aabb_collision_resolve (
	input  logic                               clk,
	input  logic                               arst_n,
	// input box pair
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// obj_center_x, obj_center_y, obj_half_w, obj_half_h,
	// ref_center_x, ref_center_y, ref_half_w, ref_half_h
	input  logic [acr_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// result
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// overlap, relation, push_x, push_y, zero pad
	output logic [acr_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

	// stage valid bits
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	acr_pkg::adv_t adv;

	// a stage may load when it is empty or its content moves on
	assign rdy3 = !v_s3 || m_tready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign adv.ld_s1 = rdy1;
	assign adv.ld_s2 = rdy2;
	assign adv.ld_s3 = rdy3;

	assign s_tready = rdy1;
	assign m_tvalid = v_s3;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1)
				v_s1 <= s_tvalid;
			if (rdy2)
				v_s2 <= v_s1;
			if (rdy3)
				v_s3 <= v_s2;
		end
	end

	// datapath
	acr_core u_core (
		.clk      (clk),
		.adv      (adv),
		.in_data  (s_tdata),
		.out_data (m_tdata)
	);

	// checks

	// a correction is given on one axis at most
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[3 +: acr_pkg::PUSH_BITS] == '0 ||
		              m_tdata[3 + acr_pkg::PUSH_BITS +: acr_pkg::PUSH_BITS] == '0))
		else $error("correction on both axes");

	// a result only appears after passing through the second stage
	a_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(v_s2))
		else $error("result valid without a second-stage item");

	// an empty output stage never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

endmodule

// ----- src/acr_core.sv -----
// ----------------------------------------------------------------------------
// acr_core: three-stage datapath of the box collision resolver
// edges, differences and half-size products, then cross products with overlap,
// relation and candidate corrections, then the axis choice into the output
// ----------------------------------------------------------------------------
module acr_core (
	input  logic                               clk,
	input  acr_pkg::adv_t                      adv,
	input  logic [acr_pkg::IN_DATA_BITS-1:0]   in_data,
	output logic [acr_pkg::OUT_DATA_BITS-1:0]  out_data
);

	localparam int CB = acr_pkg::COORD_BITS;
	localparam int HB = acr_pkg::HALF_BITS;
	localparam int EB = acr_pkg::EDGE_BITS;
	localparam int AB = acr_pkg::ABS_BITS;
	localparam int PB = acr_pkg::PUSH_BITS;
	localparam int HP = acr_pkg::HPROD_BITS;
	localparam int XP = acr_pkg::XPROD_BITS;

	// unpacked input fields
	logic signed [CB-1:0] ocx, ocy, rcx, rcy;
	logic        [HB-1:0] ohw, ohh, rhw, rhh;

	assign ocx = in_data[acr_pkg::OCX_LSB +: CB];
	assign ocy = in_data[acr_pkg::OCY_LSB +: CB];
	assign ohw = in_data[acr_pkg::OHW_LSB +: HB];
	assign ohh = in_data[acr_pkg::OHH_LSB +: HB];
	assign rcx = in_data[acr_pkg::RCX_LSB +: CB];
	assign rcy = in_data[acr_pkg::RCY_LSB +: CB];
	assign rhw = in_data[acr_pkg::RHW_LSB +: HB];
	assign rhh = in_data[acr_pkg::RHH_LSB +: HB];

	// extended operands for the edge sums
	logic signed [EB-1:0] ocx_e, ocy_e, rcx_e, rcy_e;
	logic signed [EB-1:0] ohw_e, ohh_e, rhw_e, rhh_e;
	logic signed [EB-1:0] dx, dy, dx_neg, dy_neg;

	assign ocx_e  = {ocx[CB-1], ocx};
	assign ocy_e  = {ocy[CB-1], ocy};
	assign rcx_e  = {rcx[CB-1], rcx};
	assign rcy_e  = {rcy[CB-1], rcy};
	assign ohw_e  = {{(EB-HB){1'b0}}, ohw};
	assign ohh_e  = {{(EB-HB){1'b0}}, ohh};
	assign rhw_e  = {{(EB-HB){1'b0}}, rhw};
	assign rhh_e  = {{(EB-HB){1'b0}}, rhh};
	assign dx     = ocx_e - rcx_e;
	assign dy     = ocy_e - rcy_e;
	assign dx_neg = -dx;
	assign dy_neg = -dy;

	// stage 1: box edges, centre differences and half-size products
	logic signed [EB-1:0] o_x0_s1, o_x1_s1, o_y0_s1, o_y1_s1;
	logic signed [EB-1:0] r_x0_s1, r_x1_s1, r_y0_s1, r_y1_s1;
	logic                 dx_pos_s1, dy_pos_s1;
	logic        [AB-1:0] adx_s1, ady_s1;
	logic        [HP-1:0] hx_prod_s1, hy_prod_s1;

	always_ff @(posedge clk) begin
		if (adv.ld_s1) begin
			o_x0_s1    <= ocx_e - ohw_e;
			o_x1_s1    <= ocx_e + ohw_e;
			o_y0_s1    <= ocy_e - ohh_e;
			o_y1_s1    <= ocy_e + ohh_e;
			r_x0_s1    <= rcx_e - rhw_e;
			r_x1_s1    <= rcx_e + rhw_e;
			r_y0_s1    <= rcy_e - rhh_e;
			r_y1_s1    <= rcy_e + rhh_e;
			dx_pos_s1  <= !dx[EB-1] && (dx != '0);
			dy_pos_s1  <= !dy[EB-1] && (dy != '0);
			adx_s1     <= dx[EB-1] ? dx_neg[AB-1:0] : dx[AB-1:0];
			ady_s1     <= dy[EB-1] ? dy_neg[AB-1:0] : dy[AB-1:0];
			hx_prod_s1 <= HP'(ohw) * HP'(rhw);
			hy_prod_s1 <= HP'(ohh) * HP'(rhh);
		end
	end

	// candidate corrections, extended to the push width
	logic signed [PB-1:0] px_cand, py_cand;

	assign px_cand = dx_pos_s1 ? (PB'(r_x1_s1) - PB'(o_x0_s1))
	                           : (PB'(r_x0_s1) - PB'(o_x1_s1));
	assign py_cand = dy_pos_s1 ? (PB'(r_y1_s1) - PB'(o_y0_s1))
	                           : (PB'(r_y0_s1) - PB'(o_y1_s1));

	// relation: north first, then south, then west, else east
	acr_pkg::rel_t rel_d;

	always_comb begin
		if (o_y1_s1 <= r_y0_s1)
			rel_d = acr_pkg::REL_NORTH;
		else if (o_y0_s1 >= r_y1_s1)
			rel_d = acr_pkg::REL_SOUTH;
		else if (o_x1_s1 <= r_x0_s1)
			rel_d = acr_pkg::REL_WEST;
		else
			rel_d = acr_pkg::REL_EAST;
	end

	// stage 2: cross products, overlap, relation and candidate corrections
	logic        [XP-1:0] lhs_s2, rhs_s2;
	logic                 hit_s2;
	acr_pkg::rel_t        rel_s2;
	logic signed [PB-1:0] px_s2, py_s2;

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			lhs_s2 <= XP'(adx_s1) * XP'(hy_prod_s1);
			rhs_s2 <= XP'(ady_s1) * XP'(hx_prod_s1);
			hit_s2 <= !(o_x1_s1 < r_x0_s1 || o_x0_s1 > r_x1_s1) &&
			          !(o_y1_s1 < r_y0_s1 || o_y0_s1 > r_y1_s1);
			rel_s2 <= rel_d;
			px_s2  <= px_cand;
			py_s2  <= py_cand;
		end
	end

	// stage 3: axis choice, a tie gives no correction
	logic                 hit_s3;
	acr_pkg::rel_t        rel_s3;
	logic signed [PB-1:0] px_s3, py_s3;

	always_ff @(posedge clk) begin
		if (adv.ld_s3) begin
			hit_s3 <= hit_s2;
			rel_s3 <= rel_s2;
			px_s3  <= (lhs_s2 > rhs_s2) ? px_s2 : '0;
			py_s3  <= (lhs_s2 < rhs_s2) ? py_s2 : '0;
		end
	end

	// pack the result, overlap in the lowest bit
	assign out_data = acr_pkg::OUT_DATA_BITS'({py_s3, px_s3, rel_s3, hit_s3});

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for aabb_collision_resolve
// box pairs go in on the s_ stream and results are compared field by field
// with a local predictor of overlap, relation and push-out correction; the
// stimulus is a directed set of edge cases, then random pairs in four pacing
// phases on both streams
// ----------------------------------------------------------------------------
module tb;

	// result field positions in m_tdata, lowest bit first
	localparam int OVL_BIT = 0;
	localparam int REL_LSB = 1;
	localparam int PSX_LSB = 3;
	localparam int PSY_LSB = PSX_LSB + acr_pkg::PUSH_BITS;

	// one box pair as carried on the input stream
	typedef struct {
		logic signed [acr_pkg::COORD_BITS-1:0] ocx;
		logic signed [acr_pkg::COORD_BITS-1:0] ocy;
		logic        [acr_pkg::HALF_BITS-1:0]  ohw;
		logic        [acr_pkg::HALF_BITS-1:0]  ohh;
		logic signed [acr_pkg::COORD_BITS-1:0] rcx;
		logic signed [acr_pkg::COORD_BITS-1:0] rcy;
		logic        [acr_pkg::HALF_BITS-1:0]  rhw;
		logic        [acr_pkg::HALF_BITS-1:0]  rhh;
	} box_pair_t;

	// one collision verdict
	typedef struct {
		logic                                 overlap;
		acr_pkg::rel_t                        relation;
		logic signed [acr_pkg::PUSH_BITS-1:0] push_x;
		logic signed [acr_pkg::PUSH_BITS-1:0] push_y;
	} verdict_t;

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [acr_pkg::IN_DATA_BITS-1:0]  s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [acr_pkg::OUT_DATA_BITS-1:0] m_tdata;

	verdict_t verdict_q[$];
	int       tx_idle_pct;
	int       rx_stall_pct;
	bit       stream_held;
	int       n_pairs;
	int       n_checked;
	int       n_errors;
	int       n_overlap;
	int       rel_seen[4];
	int       n_axis_x;
	int       n_axis_y;
	int       n_axis_tie;

	aabb_collision_resolve u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	always #2 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// predicted verdict for one box pair
	function automatic verdict_t resolve_pair(box_pair_t p);
		longint   ox0, ox1, oy0, oy1;
		longint   rx0, rx1, ry0, ry1;
		longint   dx, dy, adx, ady, x_weight, y_weight, px, py;
		verdict_t v;
		ox0 = longint'(p.ocx) - longint'(p.ohw);
		ox1 = longint'(p.ocx) + longint'(p.ohw);
		oy0 = longint'(p.ocy) - longint'(p.ohh);
		oy1 = longint'(p.ocy) + longint'(p.ohh);
		rx0 = longint'(p.rcx) - longint'(p.rhw);
		rx1 = longint'(p.rcx) + longint'(p.rhw);
		ry0 = longint'(p.rcy) - longint'(p.rhh);
		ry1 = longint'(p.rcy) + longint'(p.rhh);
		// closed boxes, so touching edges count
		v.overlap = !(ox1 < rx0 || ox0 > rx1) && !(oy1 < ry0 || oy0 > ry1);
		// north wins over south, south over west, the rest is east
		if (oy1 <= ry0)
			v.relation = acr_pkg::REL_NORTH;
		else if (oy0 >= ry1)
			v.relation = acr_pkg::REL_SOUTH;
		else if (ox1 <= rx0)
			v.relation = acr_pkg::REL_WEST;
		else
			v.relation = acr_pkg::REL_EAST;
		// axis choice by cross-multiplied distances, tie gives no push
		dx = longint'(p.ocx) - longint'(p.rcx);
		dy = longint'(p.ocy) - longint'(p.rcy);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		x_weight = adx * (longint'(p.ohh) * longint'(p.rhh));
		y_weight = ady * (longint'(p.ohw) * longint'(p.rhw));
		px = 0;
		py = 0;
		if (x_weight > y_weight)
			px = (dx > 0) ? rx1 - ox0 : rx0 - ox1;
		else if (x_weight < y_weight)
			py = (dy > 0) ? ry1 - oy0 : ry0 - oy1;
		v.push_x = px[acr_pkg::PUSH_BITS-1:0];
		v.push_y = py[acr_pkg::PUSH_BITS-1:0];
		return v;
	endfunction

	function automatic box_pair_t make_pair(int ocx, int ocy, int ohw, int ohh,
			int rcx, int rcy, int rhw, int rhh);
		box_pair_t p;
		p.ocx = acr_pkg::COORD_BITS'(ocx);
		p.ocy = acr_pkg::COORD_BITS'(ocy);
		p.ohw = acr_pkg::HALF_BITS'(ohw);
		p.ohh = acr_pkg::HALF_BITS'(ohh);
		p.rcx = acr_pkg::COORD_BITS'(rcx);
		p.rcy = acr_pkg::COORD_BITS'(rcy);
		p.rhw = acr_pkg::HALF_BITS'(rhw);
		p.rhh = acr_pkg::HALF_BITS'(rhh);
		return p;
	endfunction

	// drop tvalid once, if it is still held from the last transaction
	task automatic release_stream();
		if (stream_held) begin
			s_tvalid <= 1'b0;
			stream_held = 1'b0;
		end
	endtask

	// offer one box pair and wait for the transaction
	task automatic send_pair(box_pair_t p);
		logic [acr_pkg::IN_DATA_BITS-1:0] word;
		word = '0;
		word[acr_pkg::OCX_LSB +: acr_pkg::COORD_BITS] = p.ocx;
		word[acr_pkg::OCY_LSB +: acr_pkg::COORD_BITS] = p.ocy;
		word[acr_pkg::OHW_LSB +: acr_pkg::HALF_BITS]  = p.ohw;
		word[acr_pkg::OHH_LSB +: acr_pkg::HALF_BITS]  = p.ohh;
		word[acr_pkg::RCX_LSB +: acr_pkg::COORD_BITS] = p.rcx;
		word[acr_pkg::RCY_LSB +: acr_pkg::COORD_BITS] = p.rcy;
		word[acr_pkg::RHW_LSB +: acr_pkg::HALF_BITS]  = p.rhw;
		word[acr_pkg::RHH_LSB +: acr_pkg::HALF_BITS]  = p.rhh;
		s_tvalid <= 1'b1;
		s_tdata  <= word;
		stream_held = 1'b1;
		do @(posedge clk); while (!s_tready);
		verdict_q.push_back(resolve_pair(p));
		n_pairs++;
		// random sender gap
		if ($urandom_range(99) < tx_idle_pct) begin
			release_stream();
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
	endtask

	// hold the sender until every predicted result has come back
	task automatic wait_drained();
		release_stream();
		@(posedge clk);
		while (verdict_q.size() != 0) @(posedge clk);
	endtask

	function automatic int rand_coord();
		return int'($urandom_range(65535)) - 32768;
	endfunction

	// random pair, mostly near each other so every relation and axis shows up
	function automatic box_pair_t rand_pair();
		int kind, rcx, rcy, rhw, rhh, ohw, ohh, spread_x, spread_y, ox, oy;
		kind = $urandom_range(99);
		if (kind < 20)
			return make_pair(rand_coord(), rand_coord(), $urandom_range(16383),
				$urandom_range(16383), rand_coord(), rand_coord(),
				$urandom_range(16383), $urandom_range(16383));
		rcx = int'($urandom_range(40000)) - 20000;
		rcy = int'($urandom_range(40000)) - 20000;
		rhw = $urandom_range(400);
		rhh = $urandom_range(400);
		// point test now and then
		if (kind < 30) begin
			ohw = 0;
			ohh = 0;
		end else begin
			ohw = $urandom_range(400);
			ohh = $urandom_range(400);
		end
		spread_x = rhw + ohw;
		spread_y = rhh + ohh;
		if (kind < 40) begin
			// edges exactly touching on one or both axes
			ox = ($urandom_range(1) ? spread_x : -spread_x);
			oy = $urandom_range(1) ? ($urandom_range(1) ? spread_y : -spread_y)
				: int'($urandom_range(2 * spread_y)) - spread_y;
		end else begin
			ox = int'($urandom_range(2 * spread_x + 100)) - spread_x - 50;
			oy = int'($urandom_range(2 * spread_y + 100)) - spread_y - 50;
		end
		if ($urandom_range(1))
			return make_pair(rcx + ox, rcy + oy, ohw, ohh, rcx, rcy, rhw, rhh);
		return make_pair(rcx + oy, rcy + ox, ohw, ohh, rcx, rcy, rhh, rhw);
	endfunction

	task automatic report_field(string name, longint want, longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			n_errors++;
		end
	endtask

	// compare each output transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdict_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, m_tdata);
				n_errors++;
			end else begin
				want = verdict_q.pop_front();
				report_field("overlap", want.overlap, m_tdata[OVL_BIT]);
				report_field("relation", want.relation, m_tdata[REL_LSB +: 2]);
				report_field("push_x", want.push_x,
					$signed(m_tdata[PSX_LSB +: acr_pkg::PUSH_BITS]));
				report_field("push_y", want.push_y,
					$signed(m_tdata[PSY_LSB +: acr_pkg::PUSH_BITS]));
				n_checked++;
				n_overlap += want.overlap;
				rel_seen[want.relation]++;
				if (want.push_x != 0)
					n_axis_x++;
				else if (want.push_y != 0)
					n_axis_y++;
				else
					n_axis_tie++;
			end
		end
	end

	// edge cases: extremes, each relation, touching edges, ties and points
	task automatic test_directed();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(32767, 32767, 16383, 16383, -32768, -32768, 16383, 16383));
		send_pair(make_pair(-32768, -32768, 16383, 16383, 32767, 32767, 16383, 16383));
		send_pair(make_pair(-32768, -32768, 16383, 16383, -32768, -32768, 16383, 16383));
		send_pair(make_pair(100, 0, 10, 10, 80, 0, 10, 10));
		send_pair(make_pair(101, 0, 10, 10, 80, 0, 10, 10));
		send_pair(make_pair(0, -30, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(0, -20, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(0, 30, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(0, 20, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(-30, 0, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(5, 2, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(3, 4, 0, 0, 0, 0, 20, 20));
		send_pair(make_pair(50, -4, 0, 0, 0, 0, 20, 20));
		send_pair(make_pair(10, 10, 5, 5, 0, 0, 5, 5));
		send_pair(make_pair(-15, 2, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(2, 15, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(2, -15, 10, 10, 0, 0, 10, 10));
		send_pair(make_pair(5, 0, 0, 10, 0, 0, 10, 10));
		send_pair(make_pair(32767, 0, 16383, 1, -32768, 0, 16383, 1));
		send_pair(make_pair(0, -32768, 1, 16383, 0, 32767, 1, 16383));
		send_pair(make_pair(-32768, 32767, 16383, 0, 32767, -32768, 0, 16383));
		send_pair(make_pair(21845, -21846, 10922, 5461, -21846, 21845, 5461, 10922));
		wait_drained();
	endtask

	task automatic run_random(int count);
		repeat (count) send_pair(rand_pair());
		wait_drained();
	endtask

	task automatic test_back_to_back();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		run_random(420);
	endtask

	task automatic test_sender_idle();
		tx_idle_pct = 61;
		rx_stall_pct = 0;
		run_random(420);
	endtask

	task automatic test_receiver_stall();
		tx_idle_pct = 0;
		rx_stall_pct = 61;
		run_random(420);
	endtask

	task automatic test_both_idle();
		tx_idle_pct = 9;
		rx_stall_pct = 9;
		run_random(420);
	endtask

	// main sequence
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		stream_held = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_back_to_back();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		// let the pipeline settle, catching any stray result
		rx_stall_pct = 0;
		repeat (12) @(posedge clk);
		if (verdict_q.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, verdict_q.size());
			n_errors++;
		end
		$display("%0d box pairs sent, %0d results checked, %0d overlapping, %0d errors",
			n_pairs, n_checked, n_overlap, n_errors);
		$display("relations n/s/w/e %0d/%0d/%0d/%0d, push on x %0d, on y %0d, tie %0d",
			rel_seen[0], rel_seen[1], rel_seen[2], rel_seen[3],
			n_axis_x, n_axis_y, n_axis_tie);
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("%0t: run timed out", $time);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
